FILE: src/gpu_command_port_fifo_assert.svh
// Assertion macros for the GPU command port; bodies vanish under synthesis.
`ifndef GPU_COMMAND_PORT_FIFO_ASSERT_SVH
`define GPU_COMMAND_PORT_FIFO_ASSERT_SVH

`ifndef SYNTHESIS
// Condition holds at every clock edge out of reset.
`define GCPF_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Consequent holds in the same cycle as the antecedent.
`define GCPF_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Consequent holds in the cycle after the antecedent.
`define GCPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GCPF_ASSERT_ALWAYS(label, expr, msg)
`define GCPF_ASSERT_IMPLY(label, ante, cons, msg)
`define GCPF_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: src/gcpf_pkg.sv
// Package: address map, codes, FIFO sizing and shared types of the command port.
`default_nettype none

package gcpf_pkg;

  // FIFO sizing
  localparam int FIFO_DEPTH = 256;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int MSG_WORDS  = 5;
  localparam int CMD_W      = 32 * MSG_WORDS;

  // Address map
  localparam logic [31:0] UART_ADDR  = 32'h1100_0000;
  localparam logic [31:0] MSG_BASE   = 32'h2000_0008;
  localparam logic [31:0] MSG_SPAN   = 32'd20;
  localparam logic [28:0] MAGIC_BLK  = 29'(32'h2000_0000 >> 3);
  localparam logic [29:0] FLAGS_BLK  = 30'(32'h2000_001C >> 2);
  localparam logic [29:0] FRAME_BLK  = 30'(32'h2000_0020 >> 2);
  localparam logic [31:0] CLEAR_WORD = 32'd1;

  // Magic string bytes, first byte in the low bits, zero padded
  localparam logic [95:0] MAGIC = 96'h00000000_20555047_52424D45;

  // Input kinds
  typedef enum logic [2:0] {
    KIND_WRITE    = 3'd0,
    KIND_READ     = 3'd1,
    KIND_POP      = 3'd2,
    KIND_TICK     = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_t;

  // Trap codes
  typedef enum logic [1:0] {
    TRAP_NONE  = 2'd0,
    TRAP_LOAD  = 2'd1,
    TRAP_STORE = 2'd2
  } trap_t;

  // FIFO control from the decoder
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fifo_req_t;

  // FIFO status back to the decoder
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Four magic bytes starting at a byte offset
  function automatic logic [31:0] magic_word(input logic [2:0] off);
    logic [95:0] sh;
    sh = MAGIC >> {off, 3'b000};
    return sh[31:0];
  endfunction

  // Ring index advance
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] idx);
    return (idx == PTR_W'(FIFO_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

endpackage

`default_nettype wire

FILE: src/gcpf_cmd_fifo.sv
// Command ring FIFO: 160-bit word store with registered read and ring indices.
`default_nettype none

module gcpf_cmd_fifo
  import gcpf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire fifo_req_t        req,
  input  wire logic [CMD_W-1:0] push_data,
  output fifo_stat_t            stat,
  output logic      [CMD_W-1:0] pop_data
);

  logic [CMD_W-1:0] store [FIFO_DEPTH];
  logic [PTR_W-1:0] write_index;
  logic [PTR_W-1:0] read_index;

  // One slot kept free to tell full from empty
  assign stat.empty = (write_index == read_index);
  assign stat.full  = (ring_next(write_index) == read_index);

  // Ring indices; clear wins, push and pop never come together
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
    end else if (req.clear) begin
      write_index <= '0;
      read_index  <= '0;
    end else begin
      if (req.push && !stat.full) write_index <= ring_next(write_index);
      if (req.pop && !stat.empty) read_index  <= ring_next(read_index);
    end
  end

  // Store write port
  always_ff @(posedge clk) begin
    if (req.push && !stat.full && !req.clear) begin
      store[write_index] <= push_data;
    end
  end

  // Store read port, data registered
  always_ff @(posedge clk) begin
    if (req.pop) begin
      pop_data <= store[read_index];
    end
  end

endmodule

`default_nettype wire

FILE: src/gpu_command_port_fifo.sv
// Top level of the GPU command port: bus decode, message words, flags and frame counter.
//
// Usage: an access word (kind, address, write_data) is taken at a rising edge where
// start is high and busy is low. Kinds are bus write, bus read, command pop, frame
// tick and overflow report. Every accepted word yields exactly one result word on
// read_data, trap_code, uart_*, cmd_valid and cmd_word0..4, marked by done for one
// cycle, starting the cycle after acceptance.
// Throughput: one word per cycle while busy is low. The command store is a synchronous
// memory read at acceptance; its registered output forms the popped words in the cycle
// after, and a push written at one edge is visible to a pop taken at the next.
// Reset (rst, synchronous): message words, ring indices, sticky overflow and frame
// counter clear; busy stays high for the cycle after reset. The store contents are
// not cleared; only entries that were pushed can be popped.
// The receiver cannot stall: each result is valid only in its done cycle.
`default_nettype none

`include "gpu_command_port_fifo_assert.svh"

module gpu_command_port_fifo
  import gcpf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  kind,
  input  wire logic [31:0] address,
  input  wire logic [31:0] write_data,
  output logic             done,
  output logic [31:0]      read_data,
  output logic [1:0]       trap_code,
  output logic             uart_valid,
  output logic [7:0]       uart_byte,
  output logic             cmd_valid,
  output logic [31:0]      cmd_word0,
  output logic [31:0]      cmd_word1,
  output logic [31:0]      cmd_word2,
  output logic [31:0]      cmd_word3,
  output logic [31:0]      cmd_word4
);

  logic             accept;
  fifo_req_t        fifo_req;
  fifo_stat_t       fifo_stat;
  logic [CMD_W-1:0] push_data;
  logic [CMD_W-1:0] pop_data;

  logic [31:0] message_words      [MSG_WORDS];
  logic [31:0] message_words_next [MSG_WORDS];
  logic        sticky_overflow;
  logic        sticky_overflow_next;
  logic [31:0] frame_counter;
  logic [31:0] frame_counter_next;

  logic [31:0] msg_off;
  logic        msg_hit;
  logic [2:0]  msg_idx;

  logic [31:0] rd_value;
  trap_t       trap_value;
  logic        uart_v_value;
  logic        cmd_v_value;

  logic        result_cmd;
  trap_t       result_trap;

  assign accept  = start && !busy;
  assign msg_off = address - MSG_BASE;
  assign msg_hit = (msg_off < MSG_SPAN);
  assign msg_idx = msg_off[4:2];

  // Decode one access word
  always_comb begin
    for (int i = 0; i < MSG_WORDS; i++) message_words_next[i] = message_words[i];
    sticky_overflow_next = sticky_overflow;
    frame_counter_next   = frame_counter;
    fifo_req             = '0;
    push_data            = '0;
    rd_value             = '0;
    trap_value           = TRAP_NONE;
    uart_v_value         = 1'b0;
    cmd_v_value          = 1'b0;

    case (kind_t'(kind))
      KIND_WRITE: begin
        if (address == UART_ADDR) begin
          uart_v_value = 1'b1;
        end else if (msg_hit) begin
          for (int i = 0; i < MSG_WORDS; i++) begin
            if (msg_idx == 3'(i)) message_words_next[i] = write_data;
          end
          if (address == MSG_BASE) begin
            if (write_data == CLEAR_WORD) begin
              fifo_req.clear = 1'b1;
            end else begin
              // push the whole message, word 0 in the low bits, then zero it
              fifo_req.push = 1'b1;
              for (int i = 0; i < MSG_WORDS; i++) begin
                push_data[32*i +: 32] = message_words_next[i];
                message_words_next[i] = '0;
              end
            end
          end
        end else begin
          trap_value = TRAP_STORE;
        end
      end
      KIND_READ: begin
        if (address[31:3] == MAGIC_BLK) begin
          rd_value = magic_word(address[2:0]);
        end else if (address[31:2] == FLAGS_BLK) begin
          rd_value = {28'd0, fifo_stat.empty, fifo_stat.full, 1'b0, sticky_overflow};
          sticky_overflow_next = 1'b0;
        end else if (address[31:2] == FRAME_BLK) begin
          rd_value = frame_counter;
        end else begin
          trap_value = TRAP_LOAD;
        end
      end
      KIND_POP: begin
        fifo_req.pop = !fifo_stat.empty;
        cmd_v_value  = !fifo_stat.empty;
      end
      KIND_TICK: begin
        frame_counter_next = frame_counter + 32'd1;
      end
      KIND_OVERFLOW: begin
        sticky_overflow_next = 1'b1;
      end
      default: begin
      end
    endcase

    // nothing moves without an accepted word
    if (!accept) fifo_req = '0;
  end

  // Architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MSG_WORDS; i++) message_words[i] <= '0;
      sticky_overflow <= 1'b0;
      frame_counter   <= '0;
    end else if (accept) begin
      for (int i = 0; i < MSG_WORDS; i++) message_words[i] <= message_words_next[i];
      sticky_overflow <= sticky_overflow_next;
      frame_counter   <= frame_counter_next;
    end
  end

  // Busy for the cycle after reset
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      result_cmd <= 1'b0;
    end else begin
      done       <= accept;
      result_cmd <= accept && cmd_v_value;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data   <= rd_value;
      result_trap <= trap_value;
      uart_valid  <= uart_v_value;
      uart_byte   <= uart_v_value ? write_data[7:0] : 8'd0;
    end
  end

  gcpf_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .req       (fifo_req),
    .push_data (push_data),
    .stat      (fifo_stat),
    .pop_data  (pop_data)
  );

  // Popped words come straight from the store's read register
  assign trap_code = result_trap;
  assign cmd_valid = result_cmd;
  assign cmd_word0 = result_cmd ? pop_data[31:0]    : 32'd0;
  assign cmd_word1 = result_cmd ? pop_data[63:32]   : 32'd0;
  assign cmd_word2 = result_cmd ? pop_data[95:64]   : 32'd0;
  assign cmd_word3 = result_cmd ? pop_data[127:96]  : 32'd0;
  assign cmd_word4 = result_cmd ? pop_data[159:128] : 32'd0;

  // Checks
  `GCPF_ASSERT_ALWAYS(a_not_full_and_empty, !(fifo_stat.full && fifo_stat.empty), "fifo full and empty")
  `GCPF_ASSERT_IMPLY(a_cmd_in_done, cmd_valid, done, "cmd_valid outside a result cycle")
  `GCPF_ASSERT_IMPLY(a_trap_alone, done && (trap_code != TRAP_NONE), !uart_valid && !cmd_valid, "trap with side output")
  `GCPF_ASSERT_NEXT(a_pop_returns, accept && (kind == KIND_POP) && !fifo_stat.empty, cmd_valid, "pop of a filled fifo gave no command")
  `GCPF_ASSERT_NEXT(a_push_fills, accept && fifo_req.push && !fifo_stat.full, !fifo_stat.empty, "push left fifo empty")

endmodule

`default_nettype wire
